[sv/uri_enc_pkg.sv]
package uri_enc_pkg;

   // URI component selector codes.
   localparam logic [2:0] COMP_USER_INFO = 3'd0;
   localparam logic [2:0] COMP_HOST      = 3'd1;
   localparam logic [2:0] COMP_PATH      = 3'd2;
   localparam logic [2:0] COMP_QUERY     = 3'd3;
   localparam logic [2:0] COMP_FRAGMENT  = 3'd4;

   // Selector value after reset.
   localparam logic [2:0] COMP_RESET = COMP_PATH;

   // Characters that the encoder produces or tests directly.
   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;

   // One input item as it sits in the input register.
   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } item_type;

   // Upper-case hex digit for one nibble.
   function automatic logic [7:0] hex_digit(input logic [3:0] nibble);
      logic [7:0] wide;
      wide = {4'd0, nibble};
      if (nibble < 4'd10) begin
         hex_digit = 8'h30 + wide;
      end else begin
         hex_digit = 8'h37 + wide;
      end
   endfunction

endpackage

[sv/uri_enc_class.sv]
module uri_enc_class (
   input  logic [7:0] data,
   input  logic [2:0] component,
   output logic       need_enc
);

   logic alnum;
   logic unreserved;
   logic sub_delim;
   logic gen_delim;
   logic special;
   logic legal_user;
   logic legal_path;
   logic legal_query;

   // Character classes from RFC 3986.
   always_comb begin
      alnum      = (data inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]});
      // Unreserved marks: - . _ ~
      unreserved = alnum || (data inside {8'h2D, 8'h2E, 8'h5F, 8'h7E});
      // Sub-delims: ! $ & ' ( ) * + , ; =
      sub_delim  = (data inside {8'h21, 8'h24, [8'h26:8'h2C], 8'h3B, 8'h3D});
      // Gen-delims: # / : ? @ [ ]
      gen_delim  = (data inside {8'h23, 8'h2F, 8'h3A, 8'h3F, 8'h40, 8'h5B, 8'h5D});
      special    = (data == uri_enc_pkg::CHAR_PERCENT) || (data == uri_enc_pkg::CHAR_PLUS);
   end

   // Legal sets of the individual components.
   always_comb begin
      // User info adds percent and colon.
      legal_user  = unreserved || sub_delim ||
                    (data inside {uri_enc_pkg::CHAR_PERCENT, 8'h3A});
      // Path adds percent, slash, colon and at sign.
      legal_path  = unreserved || sub_delim ||
                    (data inside {uri_enc_pkg::CHAR_PERCENT, 8'h2F, 8'h3A, 8'h40});
      // Query and fragment add the question mark.
      legal_query = legal_path || (data == 8'h3F);
   end

   // Encode decision for the selected component.
   always_comb begin
      case (component)
         uri_enc_pkg::COMP_USER_INFO: need_enc = !legal_user || special;
         uri_enc_pkg::COMP_HOST:      need_enc = data[7];
         uri_enc_pkg::COMP_PATH:      need_enc = !legal_path || special;
         uri_enc_pkg::COMP_QUERY:     need_enc = !legal_query || special;
         uri_enc_pkg::COMP_FRAGMENT:  need_enc = !legal_query || special;
         // Unused selectors encode anything neither unreserved nor reserved.
         default:                     need_enc = !unreserved && !(gen_delim || sub_delim);
      endcase
   end

endmodule

[sv/uri_enc_emit.sv]
module uri_enc_emit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_valid,
   input  uri_enc_pkg::item_type item,
   input  logic                  need_enc,
   output logic                  take,
   output logic                  rsp_valid,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_run_last,
   output logic                  rsp_string_end
);

   // Triplet phase: free for a new item, or high or low digit still to send.
   localparam logic [1:0] PH_FREE = 2'd0;
   localparam logic [1:0] PH_HIGH = 2'd1;
   localparam logic [1:0] PH_LOW  = 2'd2;

   logic [1:0] phase_ff, phase_in;
   logic [7:0] hold_ff, hold_in;
   logic       hold_last_ff, hold_last_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       run_last_ff, run_last_in;
   logic       str_end_ff, str_end_in;

   // A new item is taken only when no triplet is in flight.
   assign take = item_valid && (phase_ff == PH_FREE);

   // Next result byte and triplet bookkeeping.
   always_comb begin
      phase_in     = phase_ff;
      hold_in      = hold_ff;
      hold_last_in = hold_last_ff;
      valid_in     = 1'b0;
      byte_in      = byte_ff;
      run_last_in  = 1'b0;
      str_end_in   = 1'b0;
      case (phase_ff)
         PH_FREE: begin
            if (item_valid) begin
               valid_in = 1'b1;
               if (need_enc) begin
                  byte_in      = uri_enc_pkg::CHAR_PERCENT;
                  hold_in      = item.data;
                  hold_last_in = item.last;
                  phase_in     = PH_HIGH;
               end else begin
                  byte_in     = item.data;
                  run_last_in = 1'b1;
                  str_end_in  = item.last;
               end
            end
         end
         PH_HIGH: begin
            valid_in = 1'b1;
            byte_in  = uri_enc_pkg::hex_digit(hold_ff[7:4]);
            phase_in = PH_LOW;
         end
         PH_LOW: begin
            valid_in    = 1'b1;
            byte_in     = uri_enc_pkg::hex_digit(hold_ff[3:0]);
            run_last_in = 1'b1;
            str_end_in  = hold_last_ff;
            phase_in    = PH_FREE;
         end
         default: begin
            phase_in = PH_FREE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_FREE;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         valid_ff <= valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      hold_ff      <= hold_in;
      hold_last_ff <= hold_last_in;
      byte_ff      <= byte_in;
      run_last_ff  <= run_last_in;
      str_end_ff   <= str_end_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_out_byte   = byte_ff;
   assign rsp_run_last   = run_last_ff;
   assign rsp_string_end = str_end_ff;

endmodule

[sv/uri_percent_encoder_top.sv]
// An item passes through the input register and then the result register; an item
// held behind a triplet waits in the input register until the emitter is free.
// Throughput: one item per cycle for bytes passed through with no triplet in flight;
// an encoded byte occupies the single byte-wide result register for its whole triplet.
// Results are strobed for one cycle by rsp_valid; the receiver cannot stall.
// Reset is synchronous, active high; it empties the block and selects path.
module uri_percent_encoder_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_end,
   output logic       rsp_valid,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last,
   output logic       rsp_string_end,
   input  logic       csr_we,
   input  logic [2:0] csr_wdata
);

   logic [2:0]            comp_ff;
   logic                  item_valid_ff, item_valid_in;
   uri_enc_pkg::item_type item_ff, item_in;
   logic                  need_enc;
   logic                  take;
   logic                  accept;

   // The input register is blocked while its item waits behind a triplet.
   assign busy   = item_valid_ff && !take;
   assign accept = start && !busy;

   // Component selector register.
   always_ff @(posedge clock) begin
      if (reset) begin
         comp_ff <= uri_enc_pkg::COMP_RESET;
      end else if (csr_we) begin
         comp_ff <= csr_wdata;
      end
   end

   // Input register next values.
   always_comb begin
      item_valid_in = item_valid_ff;
      item_in       = item_ff;
      if (accept) begin
         item_valid_in = 1'b1;
         item_in.data  = req_in_byte;
         item_in.last  = req_in_end;
      end else if (take) begin
         item_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   // Decide whether the held byte is encoded.
   uri_enc_class u_class (
      .data      (item_ff.data),
      .component (comp_ff),
      .need_enc  (need_enc)
   );

   // Serialize the byte or its percent triplet onto the result port.
   uri_enc_emit u_emit (
      .clock          (clock),
      .reset          (reset),
      .item_valid     (item_valid_ff),
      .item           (item_ff),
      .need_enc       (need_enc),
      .take           (take),
      .rsp_valid      (rsp_valid),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_run_last   (rsp_run_last),
      .rsp_string_end (rsp_string_end)
   );

endmodule
